// ----- design/iirl_pkg.sv -----
package iirl_pkg;

	// Fixed widths of the command and result ports.
	localparam int ACT_W   = 3;
	localparam int POS_W   = 7;
	localparam int VAL_W   = 32;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 7;

	// Defaults for the top level parameters.
	localparam int DEF_CAPACITY   = 64;
	localparam int DEF_DATA_WIDTH = 32;

	// Cells per group in the first level of the read tree.
	localparam int READ_GROUP = 16;

	typedef enum logic [ACT_W-1:0] {
		ACT_APPEND     = 3'd0,
		ACT_INSERT     = 3'd1,
		ACT_REMOVE_AT  = 3'd2,
		ACT_REMOVE_VAL = 3'd3,
		ACT_READ       = 3'd4,
		ACT_CLEAR      = 3'd5
	} action_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK       = 2'd0,
		STAT_RANGE    = 2'd1,
		STAT_FULL     = 2'd2,
		STAT_NOTFOUND = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MATCH,
		S_SCAN,
		S_GATHER,
		S_EXEC
	} state_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_FROM_LEFT,
		OP_FROM_RIGHT,
		OP_LOAD
	} cell_op_t;

	typedef struct packed {
		logic match;
		logic scan;
		logic gather;
		logic exec;
	} ctl_t;

endpackage

// ----- design/iirl_cell.sv -----
module iirl_cell import iirl_pkg::*; #(
	parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
	input  logic                  clk,
	input  cell_op_t              op,
	input  logic [DATA_WIDTH-1:0] left_data,
	input  logic [DATA_WIDTH-1:0] right_data,
	input  logic [DATA_WIDTH-1:0] load_data,
	output logic [DATA_WIDTH-1:0] data
);

	logic [DATA_WIDTH-1:0] data_q;

	// One list entry; it keeps its word, takes a neighbour's or takes a new one.
	always_ff @(posedge clk) begin
		unique case (op)
			OP_HOLD:       data_q <= data_q;
			OP_FROM_LEFT:  data_q <= left_data;
			OP_FROM_RIGHT: data_q <= right_data;
			OP_LOAD:       data_q <= load_data;
			default:       data_q <= data_q;
		endcase
	end

	assign data = data_q;

endmodule

// ----- design/iirl_ctrl.sv -----
module iirl_ctrl import iirl_pkg::*; #(
	parameter int LOG_STEPS = 6,
	parameter int STEP_W    = 3
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [ACT_W-1:0]  action,
	output logic              busy,
	output ctl_t              ctl,
	output logic [STEP_W-1:0] step
);

	state_t            state_q, state_d;
	logic [STEP_W-1:0] step_q;
	logic              last_step;

	assign last_step = (step_q == STEP_W'(LOG_STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_SCAN)
				step_q <= step_q + 1'b1;
			else
				step_q <= '0;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					if (action == ACT_REMOVE_VAL)
						state_d = S_MATCH;
					else if (action == ACT_READ)
						state_d = S_GATHER;
					else
						state_d = S_EXEC;
				end
			end
			S_MATCH:  state_d = S_SCAN;
			S_SCAN: begin
				if (last_step)
					state_d = S_EXEC;
			end
			S_GATHER: state_d = S_EXEC;
			S_EXEC:   state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		busy       = (state_q != S_IDLE);
		ctl.match  = (state_q == S_MATCH);
		ctl.scan   = (state_q == S_SCAN);
		ctl.gather = (state_q == S_GATHER);
		ctl.exec   = (state_q == S_EXEC);
	end

	assign step = step_q;

endmodule

// ----- design/indexed_insert_remove_list.sv -----
// Ordered list of up to CAPACITY data words, one word per cell in a row of
// cells that shift in parallel. A command beat is taken when start is high and
// busy is low; one result beat follows per command, marked by done for exactly
// one cycle, and the receiver cannot stall it, so it must take every result
// beat as it comes. Append, insert, remove at position and clear pass through
// the execute state only, a read first passes the gather state that registers
// the first level of its two-level read tree, and remove value first passes
// the match state and then the scan steps of the prefix scan that finds the
// first matching cell by doubling its reach once per cycle. A new command may
// be given in the same cycle as done. There is no clearing pass after reset:
// entries above the count are never read.
module indexed_insert_remove_list import iirl_pkg::*; #(
	parameter int CAPACITY   = DEF_CAPACITY,
	parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [ACT_W-1:0]   action,
	input  logic [POS_W-1:0]   position,
	input  logic [VAL_W-1:0]   value,
	output logic               done,
	output logic [STAT_W-1:0]  status,
	output logic [VAL_W-1:0]   read_value,
	output logic [COUNT_W-1:0] count
);

	// Count width, compare width, used value bits and scan steps.
	localparam int CW        = $clog2(CAPACITY + 1);
	localparam int PW        = (CW > POS_W) ? CW : POS_W;
	localparam int VW        = (DATA_WIDTH < VAL_W) ? DATA_WIDTH : VAL_W;
	localparam int LOG_STEPS = $clog2(CAPACITY);
	localparam int STEP_W    = (LOG_STEPS > 1) ? $clog2(LOG_STEPS) : 1;
	// Only cells a seven bit position can reach take part in a read.
	localparam int READ_CELLS = (CAPACITY < (1 << POS_W)) ? CAPACITY : (1 << POS_W);
	localparam int NG         = (READ_CELLS + READ_GROUP - 1) / READ_GROUP;

	ctl_t              ctl;
	logic [STEP_W-1:0] step;
	logic              accept;

	// Command registers, captured on the accepted beat.
	logic [ACT_W-1:0]      act_q;
	logic [POS_W-1:0]      pos_q;
	logic [DATA_WIDTH-1:0] val_q;

	logic [CW-1:0]         count_q, count_c;
	logic                  done_q;
	logic [STAT_W-1:0]     status_q;
	status_t               status_c;
	logic [VAL_W-1:0]      read_value_q;

	logic [PW-1:0]         pos_ext, cnt_ext;
	logic                  full;

	logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
	cell_op_t              cell_op   [CAPACITY];

	// Prefix flags of the remove value search: bit j ends up set when some
	// live cell at or below j holds the wanted value.
	logic [CAPACITY-1:0]   prefix_q, prefix_c, match_c;

	logic [DATA_WIDTH-1:0] gsel    [NG][READ_GROUP];
	logic [DATA_WIDTH-1:0] group_c [NG];
	logic [DATA_WIDTH-1:0] group_q [NG];
	logic [DATA_WIDTH-1:0] rd_c;

	logic do_append, do_insert, do_remove_at, do_remove_val, rd_ok;

	iirl_ctrl #(
		.LOG_STEPS (LOG_STEPS),
		.STEP_W    (STEP_W)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (action),
		.busy   (busy),
		.ctl    (ctl),
		.step   (step)
	);

	assign accept = start && !busy;

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= action;
			pos_q <= position;
			val_q <= DATA_WIDTH'(value[VW-1:0]);
		end
	end

	assign pos_ext = PW'(pos_q);
	assign cnt_ext = PW'(count_q);
	assign full    = (count_q == CW'(CAPACITY));

	// Outcome of the command, applied in the execute cycle.
	always_comb begin
		status_c      = STAT_OK;
		count_c       = count_q;
		do_append     = 1'b0;
		do_insert     = 1'b0;
		do_remove_at  = 1'b0;
		do_remove_val = 1'b0;
		rd_ok         = 1'b0;
		unique case (act_q)
			ACT_APPEND: begin
				if (full) begin
					status_c = STAT_FULL;
				end else begin
					do_append = 1'b1;
					count_c   = count_q + 1'b1;
				end
			end
			ACT_INSERT: begin
				// The range check comes before the full check.
				if (pos_ext > cnt_ext) begin
					status_c = STAT_RANGE;
				end else if (full) begin
					status_c = STAT_FULL;
				end else begin
					do_insert = 1'b1;
					count_c   = count_q + 1'b1;
				end
			end
			ACT_REMOVE_AT: begin
				if (pos_ext >= cnt_ext) begin
					status_c = STAT_RANGE;
				end else begin
					do_remove_at = 1'b1;
					count_c      = count_q - 1'b1;
				end
			end
			ACT_REMOVE_VAL: begin
				if (!prefix_q[CAPACITY-1]) begin
					status_c = STAT_NOTFOUND;
				end else begin
					do_remove_val = 1'b1;
					count_c       = count_q - 1'b1;
				end
			end
			ACT_READ: begin
				if (pos_ext >= cnt_ext)
					status_c = STAT_RANGE;
				else
					rd_ok = 1'b1;
			end
			ACT_CLEAR: count_c = '0;
			default: ;
		endcase
	end

	// The row of cells. Each cell decides its own move from its index.
	for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
		localparam logic [PW-1:0] J = PW'(j);
		logic [DATA_WIDTH-1:0] left_w, right_w;
		logic [LOG_STEPS-1:0]  reach;

		if (j == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_left
			assign left_w = cell_data[j-1];
		end
		if (j == CAPACITY - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_right
			assign right_w = cell_data[j+1];
		end

		always_comb begin
			cell_op[j] = OP_HOLD;
			if (ctl.exec) begin
				priority if (do_append && (J == cnt_ext))
					cell_op[j] = OP_LOAD;
				else if (do_insert && (J == pos_ext))
					cell_op[j] = OP_LOAD;
				else if (do_insert && (J > pos_ext))
					cell_op[j] = OP_FROM_LEFT;
				else if (do_remove_at && (J >= pos_ext))
					cell_op[j] = OP_FROM_RIGHT;
				else if (do_remove_val && prefix_q[j])
					cell_op[j] = OP_FROM_RIGHT;
				else
					cell_op[j] = OP_HOLD;
			end
		end

		iirl_cell #(
			.DATA_WIDTH (DATA_WIDTH)
		) u_cell (
			.clk        (clk),
			.op         (cell_op[j]),
			.left_data  (left_w),
			.right_data (right_w),
			.load_data  (val_q),
			.data       (cell_data[j])
		);

		assign match_c[j] = (cell_data[j] == val_q) && (J < cnt_ext);

		// In scan step k a flag is ORed in from the cell 2**k places lower.
		for (genvar k = 0; k < LOG_STEPS; k++) begin : g_reach
			if (j >= (1 << k)) begin : g_on
				assign reach[k] = prefix_q[j - (1 << k)] && (step == STEP_W'(k));
			end else begin : g_off
				assign reach[k] = 1'b0;
			end
		end
		assign prefix_c[j] = prefix_q[j] || (|reach);
	end

	always_ff @(posedge clk) begin
		if (ctl.match)
			prefix_q <= match_c;
		else if (ctl.scan)
			prefix_q <= prefix_c;
	end

	// Read tree: first level picks the addressed cell within each group.
	for (genvar g = 0; g < NG; g++) begin : g_group
		for (genvar i = 0; i < READ_GROUP; i++) begin : g_member
			if (g * READ_GROUP + i < READ_CELLS) begin : g_live
				assign gsel[g][i] = (pos_ext == PW'(g * READ_GROUP + i)) ?
					cell_data[g * READ_GROUP + i] : '0;
			end else begin : g_pad
				assign gsel[g][i] = '0;
			end
		end
	end

	always_comb begin
		for (int g = 0; g < NG; g++) begin
			group_c[g] = '0;
			for (int i = 0; i < READ_GROUP; i++)
				group_c[g] = group_c[g] | gsel[g][i];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.gather)
			group_q <= group_c;
	end

	always_comb begin
		rd_c = '0;
		for (int g = 0; g < NG; g++)
			rd_c = rd_c | group_q[g];
	end

	// Result beat and list length.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= ctl.exec;
			if (ctl.exec)
				count_q <= count_c;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			status_q     <= status_c;
			read_value_q <= rd_ok ? VAL_W'(rd_c[VW-1:0]) : '0;
		end
	end

	assign done       = done_q;
	assign status     = status_q;
	assign read_value = read_value_q;
	assign count      = COUNT_W'(count_q);

`ifndef SYNTHESIS
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result beat without a command in progress");

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while a command is still in progress");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("list length above capacity");

	a_full_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == STAT_FULL)) |-> (count_q == CW'(CAPACITY)))
		else $error("full status with room left");

	a_read_zero_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (read_value != '0)) |-> (status == STAT_OK))
		else $error("read data on a failed command");
`endif

endmodule

// ----- tb/iirl_checker.sv -----
`timescale 1ns / 1ps

// Watches the command and result channels of the list, keeps its own copy of
// the list contents and checks every result beat against the oldest prediction.
module iirl_checker import iirl_pkg::*; #(
	parameter int CAPACITY   = DEF_CAPACITY,
	parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic [ACT_W-1:0]   action,
	input  logic [POS_W-1:0]   position,
	input  logic [VAL_W-1:0]   value,
	input  logic               done,
	input  logic [STAT_W-1:0]  status,
	input  logic [VAL_W-1:0]   read_value,
	input  logic [COUNT_W-1:0] count,
	output int                 mismatch_count,
	output int                 results_waiting,
	output int                 results_checked,
	output int                 full_refusals
);

	typedef struct packed {
		status_t             status;
		logic [VAL_W-1:0]    read_value;
		logic [COUNT_W-1:0]  count;
	} list_result_t;

	logic [DATA_WIDTH-1:0] list_words [CAPACITY];
	int                    list_len;
	list_result_t          expected_results [$];
	list_result_t          oldest;
	list_result_t          predicted;

	// Closes the gap left by a removed entry.
	function automatic void drop_entry(input int at);
		int i;
		for (i = at; i + 1 < list_len; i++)
			list_words[i] = list_words[i + 1];
		list_len--;
	endfunction

	function automatic list_result_t apply_list_action(
		input logic [ACT_W-1:0] act,
		input logic [POS_W-1:0] pos,
		input logic [VAL_W-1:0] val
	);
		list_result_t          r;
		logic [DATA_WIDTH-1:0] key;
		int                    i;
		int                    hit;
		r.status     = STAT_OK;
		r.read_value = '0;
		key          = val[DATA_WIDTH-1:0];
		hit          = -1;
		case (act)
			ACT_APPEND: begin
				if (list_len >= CAPACITY) begin
					r.status = STAT_FULL;
				end else begin
					list_words[list_len] = key;
					list_len++;
				end
			end
			ACT_INSERT: begin
				// The range check takes precedence over the full check.
				if (int'(pos) > list_len) begin
					r.status = STAT_RANGE;
				end else if (list_len >= CAPACITY) begin
					r.status = STAT_FULL;
				end else begin
					for (i = list_len; i > int'(pos); i--)
						list_words[i] = list_words[i - 1];
					list_words[pos] = key;
					list_len++;
				end
			end
			ACT_REMOVE_AT: begin
				if (int'(pos) >= list_len)
					r.status = STAT_RANGE;
				else
					drop_entry(int'(pos));
			end
			ACT_REMOVE_VAL: begin
				for (i = 0; i < list_len; i++)
					if (hit < 0 && list_words[i] == key)
						hit = i;
				if (hit < 0)
					r.status = STAT_NOTFOUND;
				else
					drop_entry(hit);
			end
			ACT_READ: begin
				if (int'(pos) >= list_len)
					r.status = STAT_RANGE;
				else
					r.read_value = VAL_W'(list_words[pos]);
			end
			ACT_CLEAR: begin
				list_len = 0;
			end
			default: begin
			end
		endcase
		r.count = COUNT_W'(list_len);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_len        = 0;
			expected_results.delete();
			mismatch_count  = 0;
			results_waiting = 0;
			results_checked = 0;
			full_refusals   = 0;
		end else begin
			// A result beat can never belong to a command taken at the same edge.
			if (done === 1'b1) begin
				if (expected_results.size() == 0) begin
					$error("result beat with nothing outstanding: status %0d count %0d",
						status, count);
					mismatch_count++;
				end else begin
					oldest = expected_results.pop_front();
					results_checked++;
					if (status !== oldest.status) begin
						$error("status: expected %0d, got %0d", oldest.status, status);
						mismatch_count++;
					end
					if (read_value !== oldest.read_value) begin
						$error("read_value: expected %h, got %h", oldest.read_value, read_value);
						mismatch_count++;
					end
					if (count !== oldest.count) begin
						$error("count: expected %0d, got %0d", oldest.count, count);
						mismatch_count++;
					end
				end
			end
			if (start === 1'b1 && busy === 1'b0) begin
				predicted = apply_list_action(action, position, value);
				expected_results.push_back(predicted);
				if (predicted.status == STAT_FULL)
					full_refusals++;
			end
			results_waiting = expected_results.size();
		end
	end

endmodule

// ----- tb/indexed_insert_remove_list_tb.sv -----
`timescale 1ns / 1ps

// Top of the list testbench. It only generates command beats and gives the
// verdict; all prediction and comparison happens in the checker beside the
// block.
module indexed_insert_remove_list_tb;
	import iirl_pkg::*;

	localparam int CAPACITY     = DEF_CAPACITY;
	localparam int DATA_WIDTH   = DEF_DATA_WIDTH;
	localparam int RANDOM_BEATS = 1500;
	// Generous: even the slowest run, with long sender gaps on every beat and
	// the value search on each, stays far below this.
	localparam int CYCLE_LIMIT  = 400000;
	// The longest command is remove value; allow well beyond it.
	localparam int SETTLE_CYCLES = 30;
	localparam int POOL_SIZE     = 8;

	// The two action codes the block leaves undefined; they must do nothing.
	localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd6;
	localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;

	logic               clk      = 1'b0;
	logic               arst_n   = 1'b0;
	logic               start    = 1'b0;
	logic [ACT_W-1:0]   action   = ACT_APPEND;
	logic [POS_W-1:0]   position = '0;
	logic [VAL_W-1:0]   value    = '0;
	logic               busy;
	logic               done;
	logic [STAT_W-1:0]  status;
	logic [VAL_W-1:0]   read_value;
	logic [COUNT_W-1:0] count;

	int mismatch_count;
	int results_waiting;
	int results_checked;
	int full_refusals;

	int               idle_pct    = 14;
	int               beats_sent  = 0;
	int               cycle_count = 0;
	logic [COUNT_W-1:0] last_count = '0;
	logic [VAL_W-1:0] word_pool [POOL_SIZE];
	// While growing, the list is pushed towards full; while shrinking, towards
	// empty. Alternating the two drives it through both ends many times.
	logic             growing = 1'b1;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	indexed_insert_remove_list #(
		.CAPACITY   (CAPACITY),
		.DATA_WIDTH (DATA_WIDTH)
	) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.action     (action),
		.position   (position),
		.value      (value),
		.done       (done),
		.status     (status),
		.read_value (read_value),
		.count      (count)
	);

	iirl_checker #(
		.CAPACITY   (CAPACITY),
		.DATA_WIDTH (DATA_WIDTH)
	) list_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.action          (action),
		.position        (position),
		.value           (value),
		.done            (done),
		.status          (status),
		.read_value      (read_value),
		.count           (count),
		.mismatch_count  (mismatch_count),
		.results_waiting (results_waiting),
		.results_checked (results_checked),
		.full_refusals   (full_refusals)
	);

	// The length reported by the latest result beat steers the choice of
	// positions and of growing or shrinking. It may lag by one command, which
	// only blurs the bias slightly.
	always @(posedge clk) begin
		if (done === 1'b1)
			last_count <= count;
	end

	// Watchdog: a hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$error("run did not finish within %0d cycles", CYCLE_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Presents one command beat and returns at the edge that accepts it. Start
	// is left high, so a following beat with no gap keeps it high without a
	// second assignment in the same step. When the sender idles, start drops
	// for a run of cycles drawn one cycle at a time; now and then a longer
	// pause is added so that gaps also land after busy has fallen.
	task automatic send_beat(
		input logic [ACT_W-1:0] act,
		input logic [POS_W-1:0] pos,
		input logic [VAL_W-1:0] val
	);
		int gap;
		gap = 0;
		while ($urandom_range(99) < idle_pct)
			gap++;
		if (idle_pct > 0 && $urandom_range(99) < 5)
			gap += $urandom_range(12, 1);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start    <= 1'b1;
		action   <= act;
		position <= pos;
		value    <= val;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		beats_sent++;
	endtask

	// Picks one random command beat. Most beats are well formed: positions
	// inside the current list and values from a small pool, so that searches
	// hit, often among duplicates. The rest probe out of range positions,
	// fresh words that are never found, and the undefined action codes.
	task automatic send_random_beat();
		int               roll;
		int               len;
		logic [ACT_W-1:0] act;
		logic [POS_W-1:0] pos;
		logic [VAL_W-1:0] val;
		len  = int'(last_count);
		roll = $urandom_range(99);
		if (growing) begin
			if (roll < 30)      act = ACT_APPEND;
			else if (roll < 60) act = ACT_INSERT;
			else if (roll < 67) act = ACT_REMOVE_AT;
			else if (roll < 74) act = ACT_REMOVE_VAL;
			else if (roll < 97) act = ACT_READ;
			else                act = $urandom_range(1) ? ACT_SPARE_HI : ACT_SPARE_LO;
		end else begin
			if (roll < 10)      act = ACT_APPEND;
			else if (roll < 20) act = ACT_INSERT;
			else if (roll < 45) act = ACT_REMOVE_AT;
			else if (roll < 65) act = ACT_REMOVE_VAL;
			else if (roll < 93) act = ACT_READ;
			else if (roll < 95) act = ACT_CLEAR;
			else                act = $urandom_range(1) ? ACT_SPARE_HI : ACT_SPARE_LO;
		end

		if ($urandom_range(99) < 85) begin
			if (act == ACT_INSERT)
				pos = POS_W'($urandom_range(len));
			else
				pos = (len > 0) ? POS_W'($urandom_range(len - 1)) : '0;
		end else begin
			pos = POS_W'($urandom_range(CAPACITY));
		end

		roll = $urandom_range(99);
		if (roll < 60)      val = word_pool[$urandom_range(POOL_SIZE - 1)];
		else if (roll < 95) val = $urandom;
		else                val = $urandom_range(1) ? '1 : '0;

		send_beat(act, pos, val);

		// Linger at full for a few beats so that appends and inserts get
		// refused there, then start shrinking; grow again once near empty.
		if (growing && last_count >= CAPACITY && $urandom_range(7) == 0)
			growing = 1'b0;
		else if (!growing && last_count <= 1)
			growing = 1'b1;
	endtask

	initial begin
		int i;
		int directed_beats;

		word_pool[0] = '0;
		word_pool[1] = '1;
		for (i = 2; i < POOL_SIZE; i++)
			word_pool[i] = $urandom;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening. Everything on an empty list is out of range or
		// not found, and an insert may only go at position zero.
		send_beat(ACT_READ,       '0, '0);
		send_beat(ACT_REMOVE_AT,  '0, '0);
		send_beat(ACT_REMOVE_VAL, '0, '0);
		send_beat(ACT_INSERT,     7'd1, 32'h1111_1111);
		// Build the list FFFFFFFF, A5A5A5A5, 0, 12345678, 0 by inserting at the
		// front, in the middle and exactly at the end, and by appending.
		send_beat(ACT_INSERT,     '0, '1);
		send_beat(ACT_APPEND,     '0, '0);
		send_beat(ACT_APPEND,     '0, 32'h1234_5678);
		send_beat(ACT_INSERT,     7'd1, 32'hA5A5_A5A5);
		send_beat(ACT_INSERT,     7'd4, '0);
		// A position of 64 sets the top position bit; it is past the length.
		send_beat(ACT_INSERT,     7'd64, 32'h5A5A_5A5A);
		send_beat(ACT_READ,       '0, '0);
		send_beat(ACT_READ,       7'd4, '0);
		send_beat(ACT_READ,       7'd5, '0);
		send_beat(ACT_READ,       7'd64, '1);
		// Zero appears twice: only the first copy may go.
		send_beat(ACT_REMOVE_VAL, 7'd3, '0);
		send_beat(ACT_REMOVE_VAL, '0, 32'hDEAD_BEEF);
		send_beat(ACT_REMOVE_AT,  '0, '0);
		send_beat(ACT_REMOVE_AT,  7'd2, '0);
		send_beat(ACT_REMOVE_AT,  7'd2, '0);
		// Undefined codes must leave the list alone.
		send_beat(ACT_SPARE_LO,   7'd64, '1);
		send_beat(ACT_SPARE_HI,   '1, 32'h0F0F_F0F0);
		send_beat(ACT_CLEAR,      '0, '0);
		send_beat(ACT_READ,       '0, '0);
		send_beat(ACT_CLEAR,      '0, '0);
		directed_beats = beats_sent;

		// Random part in three idling phases: light, heavy, then none.
		for (i = 0; i < RANDOM_BEATS; i++) begin
			if (i == RANDOM_BEATS / 3)
				idle_pct = 69;
			else if (i == 2 * RANDOM_BEATS / 3)
				idle_pct = 0;
			send_random_beat();
		end
		start <= 1'b0;

		while (results_waiting != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		// A command whose result beat never came is a failure too.
		if (results_waiting != 0)
			$error("%0d result beats never arrived", results_waiting);

		$display("Sent %0d command beats (%0d directed) under light, heavy and no idling.",
			beats_sent, directed_beats);
		$display("Checked %0d result beats; %0d commands were refused on a full list.",
			results_checked, full_refusals);
		if (mismatch_count == 0 && results_waiting == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ----- indexed_insert_remove_list.f -----
design/iirl_pkg.sv
design/iirl_cell.sv
design/iirl_ctrl.sv
design/indexed_insert_remove_list.sv
tb/iirl_checker.sv
tb/indexed_insert_remove_list_tb.sv
